// File: rtl/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// Shared types and codes for the deque with search: request and status codes,
// the cell command set and the controller states.
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 5;

    // Request codes carried in req_type.
    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_SEARCH     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef logic signed [VALUE_W-1:0] value_t;

    // What every cell of the row does on a clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_DOWN,   // take the neighbor nearer the back
        CELL_SHIFT_UP,     // take the neighbor nearer the front
        CELL_ROTATE,       // shift down, the tail cell takes the front value
        CELL_APPEND        // only the first free cell loads the data
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        value_t   data;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_RUN
    } fsm_state_t;

endpackage

// File: rtl/dws_req_if.sv
// ----------------------------------------------------------------------------
// dws_req_if
// Request channel: valid/ready handshake with the request code and value.
// ----------------------------------------------------------------------------
interface dws_req_if;

    logic                                        valid;
    logic                                        ready;
    logic [dws_pkg::REQ_TYPE_W-1:0]              req_type;
    logic signed [dws_pkg::VALUE_W-1:0]          item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);

endinterface

// File: rtl/dws_rsp_if.sv
// ----------------------------------------------------------------------------
// dws_rsp_if
// Result channel: valid/ready handshake with status, popped value, search
// position and occupancy.
// ----------------------------------------------------------------------------
interface dws_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [dws_pkg::STATUS_W-1:0]        status;
    logic signed [dws_pkg::VALUE_W-1:0]  popped_value;
    logic [dws_pkg::POS_W-1:0]           found_position;
    logic [dws_pkg::POS_W-1:0]           occupancy;

    modport source (output valid, output status, output popped_value,
                    output found_position, output occupancy, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input found_position, input occupancy, output ready);

endinterface

// File: rtl/dws_cell.sv
// ----------------------------------------------------------------------------
// dws_cell
// One storage cell of the deque row. Cell INDEX holds the entry at position
// INDEX from the front and trades values with its two neighbors.
// ----------------------------------------------------------------------------
module dws_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  dws_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    cnt,
    input  dws_pkg::value_t     lower_value,
    input  dws_pkg::value_t     upper_value,
    input  dws_pkg::value_t     wrap_value,
    output dws_pkg::value_t     value
);

    import dws_pkg::*;

    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] TAIL_CNT = CNT_W'(INDEX + 1);

    value_t value_reg;
    value_t value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.op)
            CELL_SHIFT_DOWN: value_next = upper_value;
            CELL_SHIFT_UP:   value_next = lower_value;
            // The last held entry closes the ring by taking the front value.
            CELL_ROTATE:     value_next = (cnt == TAIL_CNT) ? wrap_value : upper_value;
            CELL_APPEND:
            begin
                if (cnt == SLOT_CNT)
                begin
                    value_next = ctrl.data;
                end
            end
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of signed 32-bit values with a search, held in
// a row of cells with the front entry in cell 0 while no rotation is running.
// ----------------------------------------------------------------------------
//
//   Channel | Modport | Payload                                          | Role
//   --------+---------+--------------------------------------------------+--------
//   req     | sink    | req_type, item_value                             | request
//   rsp     | source  | status, popped_value, found_position, occupancy  | result
//
// Push front, push back, pop front, failed or ignored requests: the result is
// registered as the request is taken. Pop back and search of n held entries:
// the row rotates one place per cycle over them, then the result is registered.
// rst_n clears the count and control state; cell contents are not reset.
// A new request is taken while a result waits, provided it is taken that cycle.
//
module deque_with_search #(
    parameter int DEPTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    dws_req_if.sink   req,
    dws_rsp_if.source rsp
);

    import dws_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fsm_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     step_reg, step_next;
    logic                 search_reg, search_next;
    value_t               key_reg, key_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    value_t               popped_reg, popped_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [POS_W-1:0]     occ_reg, occ_next;

    cell_ctrl_t           ctrl;
    value_t               cell_value [DEPTH];
    logic                 accept;
    logic                 last_step;
    logic                 hit;

    assign req.ready = (state_reg == FSM_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign last_step = (step_reg == cnt_reg - CNT_W'(1));
    assign hit       = (cell_value[0] == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        search_next    = search_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        popped_next    = popped_reg;
        position_next  = position_reg;
        occ_next       = occ_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.data      = req.item_value;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    status_next   = ST_OK;
                    popped_next   = '0;
                    position_next = '0;
                    occ_next      = POS_W'(cnt_reg);
                    unique case (req.req_type) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (cnt_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op  = (req.req_type == REQ_PUSH_FRONT) ? CELL_SHIFT_UP
                                                                            : CELL_APPEND;
                                cnt_next = cnt_reg + CNT_W'(1);
                                occ_next = POS_W'(cnt_next);
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.op     = CELL_SHIFT_DOWN;
                                popped_next = cell_value[0];
                                cnt_next    = cnt_reg - CNT_W'(1);
                                occ_next    = POS_W'(cnt_next);
                            end
                        end
                        REQ_POP_BACK, REQ_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                state_next  = FSM_RUN;
                                step_next   = '0;
                                search_next = (req.req_type == REQ_SEARCH);
                                key_next    = req.item_value;
                                found_next  = 1'b0;
                                pos_next    = '0;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            FSM_RUN:
            begin
                step_next = step_reg + CNT_W'(1);
                if (search_reg)
                begin
                    // A full turn of the ring puts every entry back in place.
                    ctrl.op = CELL_ROTATE;
                    if (!found_reg && hit)
                    begin
                        found_next = 1'b1;
                        pos_next   = POS_W'(step_reg) + POS_W'(1);
                    end
                    if (last_step)
                    begin
                        state_next     = FSM_IDLE;
                        out_valid_next = 1'b1;
                        status_next    = found_next ? ST_OK : ST_NOTFOUND;
                        popped_next    = '0;
                        position_next  = pos_next;
                        occ_next       = POS_W'(cnt_reg);
                    end
                end
                else
                begin
                    // After n-1 turns the back entry sits in cell 0 and the
                    // others follow in order, so a front pop removes it.
                    ctrl.op = last_step ? CELL_SHIFT_DOWN : CELL_ROTATE;
                    if (last_step)
                    begin
                        state_next     = FSM_IDLE;
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        popped_next    = cell_value[0];
                        position_next  = '0;
                        cnt_next       = cnt_reg - CNT_W'(1);
                        occ_next       = POS_W'(cnt_next);
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            search_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            search_reg    <= search_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        popped_reg   <= popped_next;
        position_reg <= position_next;
        occ_reg      <= occ_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        value_t lower_value;
        value_t upper_value;

        if (i == 0)
        begin : g_first
            assign lower_value = ctrl.data;
        end
        else
        begin : g_inner_lo
            assign lower_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper_value = cell_value[i];
        end
        else
        begin : g_inner_hi
            assign upper_value = cell_value[i+1];
        end

        dws_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .cnt         (cnt_reg),
            .lower_value (lower_value),
            .upper_value (upper_value),
            .wrap_value  (cell_value[0]),
            .value       (cell_value[i])
        );
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.popped_value   = popped_reg;
    assign rsp.found_position = position_reg;
    assign rsp.occupancy      = occ_reg;

`ifndef SYNTHESIS
    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("entry count exceeds the depth");

    a_run_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_RUN |-> !out_valid_reg && !req.ready)
        else $error("result or request taken while the row is rotating");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_BACK)
         && cnt_reg != FULL_CNT) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("push did not raise the entry count");

    a_run_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_RUN && last_step) |=> state_reg == FSM_IDLE && out_valid_reg)
        else $error("rotation ended without a result");
`endif

endmodule

// File: sim/deque_with_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_search_tb
// Self-checking bench for the deque with search. It drives requests and takes
// results with random gaps on both sides. A ring-buffer predictor works out
// the result of every accepted request, and each result is compared with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module deque_with_search_tb;
    import dws_pkg::*;

    localparam int DEPTH           = 16;
    localparam int MAX_GAP         = 12;
    localparam int RANDOM_ITEMS    = 1150;
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_AT        = 700;
    localparam int SETTLE_CYCLES   = 4 * (DEPTH + 1);

    // Request codes that the block ignores.
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam value_t VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        value_t              popped_value;
        logic [POS_W-1:0]    found_position;
        logic [POS_W-1:0]    occupancy;
    } deque_result_t;

    class deque_scoreboard;
        value_t          entries[DEPTH];
        int unsigned     front;
        int unsigned     count;
        deque_result_t   expected_q[$];
        int              errors;

        function new();
            front  = 0;
            count  = 0;
            errors = 0;
        endfunction

        // Applies one accepted request to the ring and queues its result.
        function void note_request(logic [REQ_TYPE_W-1:0] kind, value_t value);
            deque_result_t res;
            int unsigned   i;
            res = '0;
            case (kind)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    if (count >= DEPTH)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        if (kind == REQ_PUSH_FRONT)
                        begin
                            front = (front + DEPTH - 1) % DEPTH;
                            entries[front] = value;
                        end
                        else
                        begin
                            entries[(front + count) % DEPTH] = value;
                        end
                        count++;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (count == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.popped_value = entries[front];
                        front = (front + 1) % DEPTH;
                        count--;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (count == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.popped_value = entries[(front + count - 1) % DEPTH];
                        count--;
                    end
                end
                REQ_SEARCH:
                begin
                    if (count == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        res.status = ST_NOTFOUND;
                        // Only the match nearest the front counts.
                        for (i = 0; i < count; i++)
                        begin
                            if (res.status == ST_NOTFOUND &&
                                entries[(front + i) % DEPTH] == value)
                            begin
                                res.status         = ST_OK;
                                res.found_position = POS_W'(i + 1);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res.occupancy = POS_W'(count);
            expected_q.push_back(res);
        endfunction

        function void check_result(deque_result_t got);
            deque_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d popped %0d position %0d occupancy %0d",
                         $time, got.status, got.popped_value, got.found_position,
                         got.occupancy);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.popped_value !== want.popped_value ||
                got.found_position !== want.found_position ||
                got.occupancy !== want.occupancy)
            begin
                $display("%0t: expected status %0d popped %0d position %0d occupancy %0d",
                         $time, want.status, want.popped_value, want.found_position,
                         want.occupancy);
                $display("%0t: actual   status %0d popped %0d position %0d occupancy %0d",
                         $time, got.status, got.popped_value, got.found_position,
                         got.occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    deque_scoreboard sb;
    int              sent_count;
    int              received_count;
    value_t          value_pool[8];

    dws_req_if req_ch();
    dws_rsp_if rsp_ch();

    deque_with_search #(
        .DEPTH(DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("deque_with_search_tb NOT OK");
        $finish;
    end

    // Called away from a falling edge; returns at the edge that takes the item.
    task automatic send_request(input logic [REQ_TYPE_W-1:0] kind, input value_t value);
        int gap;
        gap = ((sent_count / 50) % 5 == 4) ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.item_value <= value;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        sb.note_request(kind, value);
        sent_count++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    function automatic value_t pick_value();
        if ($urandom_range(0, 99) < 60)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Phases lean toward filling, draining or mixed traffic so that both the
    // full and the empty queue come up often.
    function automatic logic [REQ_TYPE_W-1:0] pick_kind(int idx);
        int roll;
        int phase;
        int push_limit;
        int pop_limit;
        phase = (idx / 40) % 3;
        roll  = $urandom_range(0, 99);
        if (roll < 4)
        begin
            case ($urandom_range(0, 2))
                0:       return REQ_SPARE_5;
                1:       return REQ_SPARE_6;
                default: return REQ_SPARE_7;
            endcase
        end
        case (phase)
            0:
            begin
                push_limit = 70;
                pop_limit  = 85;
            end
            1:
            begin
                push_limit = 15;
                pop_limit  = 85;
            end
            default:
            begin
                push_limit = 35;
                pop_limit  = 65;
            end
        endcase
        if (roll < push_limit)
            return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        if (roll < pop_limit)
            return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        return REQ_SEARCH;
    endfunction

    // Result side: random stalls, stall-free stretches, and one long hold-off.
    initial
    begin
        int            stall;
        deque_result_t got;
        rsp_ch.ready   = 1'b0;
        received_count = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = ((received_count / 60) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
            if (received_count == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (rsp_ch.valid !== 1'b1);
            got.status         = rsp_ch.status;
            got.popped_value   = rsp_ch.popped_value;
            got.found_position = rsp_ch.found_position;
            got.occupancy      = rsp_ch.occupancy;
            sb.check_result(got);
            received_count++;
        end
    end

    initial
    begin
        int i;
        sb                = new();
        sent_count        = 0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_PUSH_FRONT;
        req_ch.item_value = '0;
        value_pool[0] = VALUE_MIN;
        value_pool[1] = VALUE_MAX;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests on an empty queue, then the value extremes and duplicates.
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_SEARCH, '0);
        send_request(REQ_SPARE_5, VALUE_MAX);
        send_request(REQ_PUSH_FRONT, VALUE_MIN);
        send_request(REQ_PUSH_BACK, VALUE_MAX);
        send_request(REQ_PUSH_FRONT, -1);
        send_request(REQ_PUSH_BACK, -1);
        send_request(REQ_SEARCH, -1);
        send_request(REQ_SEARCH, VALUE_MAX);
        send_request(REQ_SEARCH, '0);
        send_request(REQ_SPARE_7, VALUE_MIN);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);

        // Fill to the brim, push into the full queue, and find the last entry.
        for (i = 0; i < DEPTH - 2; i++)
            send_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, value_t'(i));
        send_request(REQ_PUSH_FRONT, VALUE_MIN);
        send_request(REQ_PUSH_BACK, VALUE_MAX);
        send_request(REQ_SEARCH, value_t'(DEPTH - 3));

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == DRAIN_AT)
            begin
                stop_sending();
                while (sb.pending() > 0)
                    @(posedge clk);
            end
            send_request(pick_kind(i), pick_value());
        end

        stop_sending();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("deque_with_search_tb OK");
        else
            $display("deque_with_search_tb NOT OK");
        $finish;
    end

endmodule
